// ===== src/mfvr_pkg.sv =====
package mfvr_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int HL_W      = DATA_W + 3;
    localparam int MAGV_W    = DATA_W + 1;
    localparam int PROD_W    = MAGV_W + HL_W;
    localparam int DIV_W     = DATA_W + 2;
    localparam int Q_W       = DATA_W + 1;
    localparam int TERM_W    = DATA_W + 3;
    localparam int SPLIT_W   = (HL_W + 1) / 2;
    localparam int PP_W      = MAGV_W + SPLIT_W;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [Q_W-1:0] Q_CAP = {1'b1, {DATA_W{1'b0}}};
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_FULL  = 2'd2
    } fill_t;

    // controller -> datapath
    typedef struct packed {
        logic hist_en;
        logic cap_en;
        logic first;
        logic slope_en;
        logic mul_en;
        logic mul_hi;
        logic div_init;
        logic div_force;
        logic div_step;
        logic sign_en;
        logic load_out;
    } mfvr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hc_zero;
        logic div_over;
    } mfvr_sts_t;

    function automatic diff_t minmod(input diff_t a, input diff_t b);
        diff_t r;
        if (a >= 0 && b >= 0) begin
            r = (a < b) ? a : b;
        end else if (a <= 0 && b <= 0) begin
            r = (a > b) ? a : b;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== src/mfvr_ctrl.sv =====
module mfvr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_row_first,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    input  mfvr_pkg::mfvr_sts_t sts,
    output mfvr_pkg::mfvr_cmd_t cmd
);
    import mfvr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOPE,
        ST_MUL0,
        ST_MUL1,
        ST_DCHK,
        ST_DIV,
        ST_SGN,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    fill_t             fill_reg, fill_next;
    logic              first_pend_reg, first_pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              row_start;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign row_start = s_row_first || (fill_reg == FILL_EMPTY);

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        first_pend_next = first_pend_reg;
        cnt_next        = cnt_reg;
        cmd             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.hist_en = 1'b1;
                    if (row_start) begin
                        fill_next       = FILL_ONE;
                        first_pend_next = 1'b1;
                    end else if (fill_reg == FILL_ONE) begin
                        fill_next = FILL_FULL;
                    end else begin
                        cmd.cap_en      = 1'b1;
                        cmd.first       = first_pend_reg;
                        first_pend_next = 1'b0;
                        state_next      = ST_SLOPE;
                    end
                end
            end
            ST_SLOPE: begin
                cmd.slope_en = 1'b1;
                state_next   = ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_hi = 1'b1;
                state_next = ST_DCHK;
            end
            ST_DCHK: begin
                // zero depth or quotient past 33 bits: no divide needed
                if (sts.hc_zero || sts.div_over) begin
                    cmd.div_force = 1'b1;
                    state_next    = ST_SGN;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = CNT_LAST;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SGN;
                end
            end
            ST_SGN: begin
                cmd.sign_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= FILL_EMPTY;
            first_pend_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            first_pend_reg <= first_pend_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

// ===== src/mfvr_dpath.sv =====
module mfvr_dpath (
    input  logic                           aclk,
    input  logic signed [mfvr_pkg::DATA_W-1:0] s_depth,
    input  logic signed [mfvr_pkg::DATA_W-1:0] s_velocity,
    input  mfvr_pkg::mfvr_cmd_t             cmd,
    output mfvr_pkg::mfvr_sts_t             sts,
    output logic signed [mfvr_pkg::DATA_W-1:0] m_face_velocity,
    output logic                           m_row_edge,
    output logic                           m_arith_error
);
    import mfvr_pkg::*;

    // sample history
    data_t dprev_reg, dprev2_reg, vprev_reg, vprev2_reg;

    // captured operands
    data_t hc_reg, vc_reg;
    diff_t dhb_reg, dhf_reg, dvb_reg, dvf_reg;
    logic  first_reg;

    // slope stage
    logic [MAGV_W-1:0] magv_reg;
    logic [HL_W-1:0]   magh_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic              hczero_reg;

    // multiply / divide
    logic [PROD_W-1:0] prod_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [Q_W-1:0]    low_reg;
    logic [Q_W-1:0]    q_reg;
    logic              err_reg;
    logic signed [TERM_W-1:0] term_reg;

    logic signed [DATA_W-1:0] fv_reg;
    logic                     edge_reg;
    logic                     aerr_reg;

    diff_t                    mh, mv;
    logic signed [HL_W-1:0]   hc2, hl2;
    logic [DATA_W-1:0]        hc_mag;
    logic [SPLIT_W-1:0]       mul_b;
    logic [PP_W-1:0]          pp;
    logic [DIV_W:0]           rem_sh;
    logic [DIV_W:0]           rem_diff;
    logic [Q_W-1:0]           q_clamp;
    logic signed [TERM_W-1:0] term_mag;
    logic signed [TERM_W-1:0] sum;
    logic                     sat_hi, sat_lo;
    logic signed [TERM_W-1:0] max_ext, min_ext;

    always_comb begin
        mh     = minmod(dhb_reg, dhf_reg);
        mv     = minmod(dvb_reg, dvf_reg);
        hc2    = HL_W'(hc_reg) <<< 1;
        hl2    = first_reg ? (hc2 + HL_W'(mh)) : (hc2 - HL_W'(mh));
        hc_mag = hc_reg[DATA_W-1] ? DATA_W'(-hc_reg) : DATA_W'(hc_reg);
    end

    assign mul_b = cmd.mul_hi ? SPLIT_W'(magh_reg[HL_W-1:SPLIT_W])
                              : magh_reg[SPLIT_W-1:0];
    assign pp    = PP_W'(magv_reg) * PP_W'(mul_b);

    assign rem_sh   = {rem_reg, low_reg[Q_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    assign sts.hc_zero  = hczero_reg;
    assign sts.div_over = prod_reg[PROD_W-1:Q_W] >= {1'b0, dvs_reg};

    assign q_clamp  = (q_reg > Q_CAP) ? Q_CAP : q_reg;
    assign term_mag = $signed(TERM_W'(q_clamp));

    assign max_ext = TERM_W'({1'b0, {(DATA_W-1){1'b1}}});
    assign min_ext = -max_ext - TERM_W'(1);
    assign sum     = TERM_W'(vc_reg) + term_reg;
    assign sat_hi  = sum > max_ext;
    assign sat_lo  = sum < min_ext;

    always_ff @(posedge aclk) begin
        if (cmd.hist_en) begin
            dprev2_reg <= dprev_reg;
            vprev2_reg <= vprev_reg;
            dprev_reg  <= s_depth;
            vprev_reg  <= s_velocity;
        end
        if (cmd.cap_en) begin
            hc_reg    <= dprev_reg;
            vc_reg    <= vprev_reg;
            dhb_reg   <= DIFF_W'(dprev_reg) - DIFF_W'(dprev2_reg);
            dhf_reg   <= DIFF_W'(s_depth) - DIFF_W'(dprev_reg);
            dvb_reg   <= DIFF_W'(vprev_reg) - DIFF_W'(vprev2_reg);
            dvf_reg   <= DIFF_W'(s_velocity) - DIFF_W'(vprev_reg);
            first_reg <= cmd.first;
        end
        if (cmd.slope_en) begin
            magv_reg   <= mv[DIFF_W-1] ? MAGV_W'(-mv) : MAGV_W'(mv);
            magh_reg   <= hl2[HL_W-1] ? HL_W'(-hl2) : HL_W'(hl2);
            dvs_reg    <= {hc_mag, 2'b00};
            neg_reg    <= mv[DIFF_W-1] ^ hl2[HL_W-1] ^ hc_reg[DATA_W-1];
            hczero_reg <= (hc_reg == '0);
        end
        if (cmd.mul_en) begin
            if (cmd.mul_hi) begin
                prod_reg <= prod_reg + (PROD_W'(pp) << SPLIT_W);
            end else begin
                prod_reg <= PROD_W'(pp);
            end
        end
        if (cmd.div_force) begin
            q_reg   <= (prod_reg == '0) ? '0 : Q_CAP;
            err_reg <= hczero_reg;
        end else if (cmd.div_init) begin
            // high part is below the divisor here, so it fits DIV_W bits
            rem_reg <= prod_reg[PROD_W-2:Q_W];
            low_reg <= prod_reg[Q_W-1:0];
            q_reg   <= '0;
            err_reg <= 1'b0;
        end else if (cmd.div_step) begin
            if (!rem_diff[DIV_W]) begin
                rem_reg <= rem_diff[DIV_W-1:0];
            end else begin
                rem_reg <= rem_sh[DIV_W-1:0];
            end
            q_reg   <= {q_reg[Q_W-2:0], ~rem_diff[DIV_W]};
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
        end
        if (cmd.sign_en) begin
            term_reg <= neg_reg ? -term_mag : term_mag;
        end
        if (cmd.load_out) begin
            if (sat_hi) begin
                fv_reg <= max_ext[DATA_W-1:0];
            end else if (sat_lo) begin
                fv_reg <= min_ext[DATA_W-1:0];
            end else begin
                fv_reg <= sum[DATA_W-1:0];
            end
            edge_reg <= first_reg;
            aerr_reg <= err_reg | sat_hi | sat_lo;
        end
    end

    assign m_face_velocity = fv_reg;
    assign m_row_edge      = edge_reg;
    assign m_arith_error   = aerr_reg;

endmodule

// ===== src/minmod_face_velocity_reconstruct.sv =====
// Minmod face-velocity reconstruction, one request at a time.
// Input channel s_*: depth and velocity (signed Q16.16) plus s_row_first,
// which starts a new row. The first two samples of a row only fill the
// history and give no result. Every later sample gives one result on m_*
// for the centre cell (the previous sample): m_face_velocity (Q16.16,
// saturated), m_row_edge (first result of the row) and m_arith_error.
// A sample that gives no result is taken by the idle state alone. A result
// sample passes slope, a two-pass 33x18 multiply, divisor check, a radix-2
// restoring divider, sign and output before m_valid rises. A zero centre
// depth or a quotient that overflows skips the divider. s_ready is high
// only between requests, so a new sample is taken only once the last
// request has been loaded into the output register.
// m_* comes from an output register: a new sample is accepted while a
// result waits, and when m_ready stays low the finished request waits in
// the last step until the register frees up.
// Reset (aresetn low, synchronous) clears the row history and the output
// valid, so the next sample starts a new row.
module minmod_face_velocity_reconstruct (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mfvr_pkg::DATA_W-1:0] s_depth,
    input  logic signed [mfvr_pkg::DATA_W-1:0] s_velocity,
    input  logic                               s_row_first,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mfvr_pkg::DATA_W-1:0] m_face_velocity,
    output logic                               m_row_edge,
    output logic                               m_arith_error
);
    import mfvr_pkg::*;

    mfvr_cmd_t cmd;
    mfvr_sts_t sts;

    mfvr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_row_first (s_row_first),
        .s_ready     (s_ready),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .sts         (sts),
        .cmd         (cmd)
    );

    mfvr_dpath u_dpath (
        .aclk            (aclk),
        .s_depth         (s_depth),
        .s_velocity      (s_velocity),
        .cmd             (cmd),
        .sts             (sts),
        .m_face_velocity (m_face_velocity),
        .m_row_edge      (m_row_edge),
        .m_arith_error   (m_arith_error)
    );

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register overwritten while a result waits");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.mul_en || cmd.div_step || cmd.sign_en || cmd.load_out))
        else $error("datapath busy while taking requests");

    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !cmd.load_out) |=> !m_valid)
        else $error("result presented twice");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_out))
        else $error("result valid without a load");

endmodule
